### rtl/mcv_pkg.sv
// ----------------------------------------------------------------------------
// mcv_pkg
// Shared types, operation codes and helpers for the mutex/condvar manager.
// ----------------------------------------------------------------------------
package mcv_pkg;

    localparam int NumLocks = 16;
    localparam int NumConds = 16;
    localparam int NumPids  = 32;

    localparam logic [2:0] OP_LOCK_CREATE = 3'd0;
    localparam logic [2:0] OP_ACQUIRE     = 3'd1;
    localparam logic [2:0] OP_RELEASE     = 3'd2;
    localparam logic [2:0] OP_TRANSFER    = 3'd3;
    localparam logic [2:0] OP_COND_CREATE = 3'd4;
    localparam logic [2:0] OP_COND_WAIT   = 3'd5;
    localparam logic [2:0] OP_COND_SIGNAL = 3'd6;

    typedef struct packed {
        logic [4:0] target_pid;
        logic [4:0] caller_pid;
        logic [3:0] handle;
        logic [2:0] operation;
    } item_t;

    typedef struct packed {
        logic [4:0] wake_pid;
        logic       wake_valid;
        logic       caller_sleeps;
        logic [3:0] new_handle;
        logic       status;
    } result_t;

    // queue-indexed memories (head, tail) and pid-indexed (next waiter)
    typedef struct packed {
        logic       we;
        logic [4:0] waddr;
        logic [4:0] wdata;
        logic [4:0] raddr;
    } qmem_req_t;

    // lock owner pid
    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [4:0] wdata;
        logic [3:0] raddr;
    } own_req_t;

    // condition -> bound lock
    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [3:0] wdata;
        logic [3:0] raddr;
    } bnd_req_t;

    // lowest clear bit: {found, index}
    function automatic logic [4:0] find_free(input logic [15:0] used);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (!used[i]) begin
                r = {1'b1, 4'(i)};
            end
        end
        return r;
    endfunction

endpackage

### rtl/mcv_ram.sv
// ----------------------------------------------------------------------------
// mcv_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcv_ram #(
    parameter int AW = 5,
    parameter int DW = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/mcv_seq.sv
// ----------------------------------------------------------------------------
// mcv_seq
// Request sequencer: flag bits, table read-modify-write and queue walks.
// ----------------------------------------------------------------------------
module mcv_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  mcv_pkg::item_t     in_item,
    input  logic               out_free,
    output logic               res_valid,
    output mcv_pkg::result_t   res,
    output mcv_pkg::qmem_req_t head_req,
    output mcv_pkg::qmem_req_t tail_req,
    output mcv_pkg::qmem_req_t next_req,
    output mcv_pkg::own_req_t  own_req,
    output mcv_pkg::bnd_req_t  bnd_req,
    input  logic [4:0]         head_rd,
    input  logic [4:0]         tail_rd,
    input  logic [4:0]         next_rd,
    input  logic [4:0]         own_rd,
    input  logic [3:0]         bnd_rd
);
    import mcv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_BOUND, S_OWNER, S_ENQ, S_ENQ_WR, S_DQ_RD, S_DQ_H,
        S_DQ_N, S_WALK0, S_WALK, S_WALK_N, S_UNLINK, S_FIN
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [3:0]  h_reg, h_next;
    logic [4:0]  caller_reg, caller_next;
    logic [4:0]  target_reg, target_next;
    logic [3:0]  lk_reg, lk_next;
    logic [4:0]  q_reg, q_next;
    logic [4:0]  wp_reg, wp_next;
    logic [4:0]  cur_reg, cur_next;
    logic [4:0]  prev_reg, prev_next;
    logic [4:0]  tl_reg, tl_next;
    logic        first_reg, first_next;
    result_t     res_reg, res_next;

    logic [15:0] lk_use_reg, lk_use_next;
    logic [15:0] owned_reg, owned_next;
    logic [15:0] cd_use_reg, cd_use_next;
    logic [31:0] qne_reg, qne_next;
    logic [31:0] wait_reg, wait_next;

    logic        enq_fin, dq_fin, is_owner;
    logic [4:0]  dq_pid, free_lk, free_cd;
    logic [4:0]  lq;

    assign free_lk = find_free(lk_use_reg);
    assign free_cd = find_free(cd_use_reg);
    assign lq = {1'b0, lk_reg};
    assign is_owner = owned_reg[lk_reg] && (own_rd == caller_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign res = res_reg;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg; h_next = h_reg; caller_next = caller_reg;
        target_next = target_reg; lk_next = lk_reg; q_next = q_reg;
        wp_next = wp_reg; cur_next = cur_reg; prev_next = prev_reg;
        tl_next = tl_reg; first_next = first_reg; res_next = res_reg;
        lk_use_next = lk_use_reg; owned_next = owned_reg;
        cd_use_next = cd_use_reg; qne_next = qne_reg; wait_next = wait_reg;
        head_req = '0; tail_req = '0; next_req = '0; own_req = '0; bnd_req = '0;
        enq_fin = 1'b0; dq_fin = 1'b0; dq_pid = wp_reg;
        res_valid = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next = in_item.operation;
                    h_next = in_item.handle;
                    caller_next = in_item.caller_pid;
                    target_next = in_item.target_pid;
                    res_next = '0;
                    res_next.status = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FIN;
                lk_next = h_reg;
                own_req.raddr = h_reg;
                bnd_req.raddr = h_reg;
                if (!wait_reg[caller_reg]) begin
                    case (op_reg)
                        OP_LOCK_CREATE: begin
                            if (free_lk[4]) begin
                                lk_use_next[free_lk[3:0]] = 1'b1;
                                owned_next[free_lk[3:0]] = 1'b0;
                                qne_next[{1'b0, free_lk[3:0]}] = 1'b0;
                                res_next.new_handle = free_lk[3:0];
                                res_next.status = 1'b0;
                            end
                        end
                        OP_COND_CREATE: begin
                            if (lk_use_reg[h_reg] && free_cd[4]) begin
                                cd_use_next[free_cd[3:0]] = 1'b1;
                                bnd_req.we = 1'b1;
                                bnd_req.waddr = free_cd[3:0];
                                bnd_req.wdata = h_reg;
                                qne_next[{1'b1, free_cd[3:0]}] = 1'b0;
                                res_next.new_handle = free_cd[3:0];
                                res_next.status = 1'b0;
                            end
                        end
                        OP_ACQUIRE, OP_RELEASE, OP_TRANSFER: begin
                            if (lk_use_reg[h_reg]) begin
                                state_next = S_OWNER;
                            end
                        end
                        OP_COND_WAIT, OP_COND_SIGNAL: begin
                            if (cd_use_reg[h_reg]) begin
                                state_next = S_BOUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BOUND: begin
                lk_next = bnd_rd;
                own_req.raddr = bnd_rd;
                state_next = S_OWNER;
            end
            S_OWNER: begin
                state_next = S_FIN;
                head_req.raddr = lq;
                tail_req.raddr = lq;
                case (op_reg)
                    OP_ACQUIRE: begin
                        res_next.status = 1'b0;
                        if (owned_reg[lk_reg]) begin
                            if (own_rd != caller_reg) begin
                                q_next = lq;
                                state_next = S_ENQ;
                            end
                        end else begin
                            owned_next[lk_reg] = 1'b1;
                            own_req.we = 1'b1;
                            own_req.waddr = lk_reg;
                            own_req.wdata = caller_reg;
                        end
                    end
                    OP_RELEASE: begin
                        if (is_owner) begin
                            res_next.status = 1'b0;
                            if (qne_reg[lq]) begin
                                q_next = lq;
                                state_next = S_DQ_RD;
                            end else begin
                                owned_next[lk_reg] = 1'b0;
                            end
                        end
                    end
                    OP_TRANSFER: begin
                        if (is_owner) begin
                            res_next.status = 1'b0;
                            own_req.we = 1'b1;
                            own_req.waddr = lk_reg;
                            own_req.wdata = target_reg;
                            if (wait_reg[target_reg] && qne_reg[lq]) begin
                                state_next = S_WALK0;
                            end
                        end
                    end
                    OP_COND_WAIT: begin
                        if (is_owner) begin
                            res_next.status = 1'b0;
                            q_next = {1'b1, h_reg};
                            state_next = S_ENQ;
                        end
                    end
                    OP_COND_SIGNAL: begin
                        if (is_owner) begin
                            res_next.status = 1'b0;
                            if (qne_reg[{1'b1, h_reg}]) begin
                                q_next = {1'b1, h_reg};
                                state_next = S_DQ_RD;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_ENQ: begin
                if (qne_reg[q_reg]) begin
                    tail_req.raddr = q_reg;
                    state_next = S_ENQ_WR;
                end else begin
                    head_req.we = 1'b1;
                    head_req.waddr = q_reg;
                    head_req.wdata = caller_reg;
                    tail_req.we = 1'b1;
                    tail_req.waddr = q_reg;
                    tail_req.wdata = caller_reg;
                    qne_next[q_reg] = 1'b1;
                    wait_next[caller_reg] = 1'b1;
                    enq_fin = 1'b1;
                end
            end
            S_ENQ_WR: begin
                next_req.we = 1'b1;
                next_req.waddr = tail_rd;
                next_req.wdata = caller_reg;
                tail_req.we = 1'b1;
                tail_req.waddr = q_reg;
                tail_req.wdata = caller_reg;
                wait_next[caller_reg] = 1'b1;
                enq_fin = 1'b1;
            end
            S_DQ_RD: begin
                head_req.raddr = q_reg;
                tail_req.raddr = q_reg;
                state_next = S_DQ_H;
            end
            S_DQ_H: begin
                wp_next = head_rd;
                next_req.raddr = head_rd;
                if (head_rd == tail_rd) begin
                    qne_next[q_reg] = 1'b0;
                    wait_next[head_rd] = 1'b0;
                    dq_pid = head_rd;
                    dq_fin = 1'b1;
                end else begin
                    state_next = S_DQ_N;
                end
            end
            S_DQ_N: begin
                head_req.we = 1'b1;
                head_req.waddr = q_reg;
                head_req.wdata = next_rd;
                wait_next[wp_reg] = 1'b0;
                dq_fin = 1'b1;
            end
            S_WALK0: begin
                cur_next = head_rd;
                tl_next = tail_rd;
                first_next = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: begin
                next_req.raddr = cur_reg;
                state_next = S_WALK_N;
                if (cur_reg == target_reg) begin
                    if (cur_reg == tl_reg) begin
                        if (first_reg) begin
                            qne_next[lq] = 1'b0;
                        end else begin
                            tail_req.we = 1'b1;
                            tail_req.waddr = lq;
                            tail_req.wdata = prev_reg;
                        end
                        wait_next[target_reg] = 1'b0;
                        res_next.wake_valid = 1'b1;
                        res_next.wake_pid = target_reg;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_UNLINK;
                    end
                end else if (cur_reg == tl_reg) begin
                    state_next = S_FIN;
                end else begin
                    prev_next = cur_reg;
                    first_next = 1'b0;
                end
            end
            S_WALK_N: begin
                cur_next = next_rd;
                state_next = S_WALK;
            end
            S_UNLINK: begin
                if (first_reg) begin
                    head_req.we = 1'b1;
                    head_req.waddr = lq;
                    head_req.wdata = next_rd;
                end else begin
                    next_req.we = 1'b1;
                    next_req.waddr = prev_reg;
                    next_req.wdata = next_rd;
                end
                wait_next[target_reg] = 1'b0;
                res_next.wake_valid = 1'b1;
                res_next.wake_pid = target_reg;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // caller queued: lock queue for acquire/signal, cond queue for wait
        if (enq_fin) begin
            res_next.caller_sleeps = 1'b1;
            state_next = S_FIN;
            if (op_reg == OP_COND_WAIT) begin
                if (qne_reg[lq]) begin
                    q_next = lq;
                    state_next = S_DQ_RD;
                end else begin
                    owned_next[lk_reg] = 1'b0;
                end
            end
        end

        // head popped: it now owns the lock and is woken
        if (dq_fin) begin
            own_req.we = 1'b1;
            own_req.waddr = lk_reg;
            own_req.wdata = dq_pid;
            res_next.wake_valid = 1'b1;
            res_next.wake_pid = dq_pid;
            state_next = S_FIN;
            if (op_reg == OP_COND_SIGNAL) begin
                q_next = lq;
                state_next = S_ENQ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lk_use_reg <= '0;
            owned_reg <= '0;
            cd_use_reg <= '0;
            qne_reg <= '0;
            wait_reg <= '0;
        end else begin
            state_reg <= state_next;
            lk_use_reg <= lk_use_next;
            owned_reg <= owned_next;
            cd_use_reg <= cd_use_next;
            qne_reg <= qne_next;
            wait_reg <= wait_next;
        end
        op_reg <= op_next;
        h_reg <= h_next;
        caller_reg <= caller_next;
        target_reg <= target_next;
        lk_reg <= lk_next;
        q_reg <= q_next;
        wp_reg <= wp_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        tl_reg <= tl_next;
        first_reg <= first_next;
        res_reg <= res_next;
    end
endmodule

### rtl/mutex_and_condvar_manager_core.sv
// Steps: creates and requests refused at decode go from decode straight to the result;
// acquire, release, transfer and the condition operations read the owner table and may
// go on through the queue states; a transfer whose target sits in the lock queue walks
// the queue one queued process at a time until it reaches the target or the tail.
// Throughput: one request at a time; the next input transfer is taken once the
// sequencer has passed its result to the output register.
// Reset: synchronous aresetn clears all flag bits; table memories are not cleared.
// ----------------------------------------------------------------------------
// mutex_and_condvar_manager_core
// Mutex and condition-variable manager with FIFO wait queues, built around
// small synchronous tables and a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module mutex_and_condvar_manager_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], handle[6:3], caller_pid[11:7], target_pid[16:12], zero pad
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], new_handle[4:1], caller_sleeps[5], wake_valid[6], wake_pid[11:7], pad
    output logic [15:0] m_tdata
);
    import mcv_pkg::*;

    item_t     item;
    result_t   res;
    logic      res_valid, out_free;
    qmem_req_t head_req, tail_req, next_req;
    own_req_t  own_req;
    bnd_req_t  bnd_req;
    logic [4:0] head_rd, tail_rd, next_rd, own_rd;
    logic [3:0] bnd_rd;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    assign item = s_tdata[16:0];

    // Sequencer owns all control and flag state
    mcv_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .head_req  (head_req),
        .tail_req  (tail_req),
        .next_req  (next_req),
        .own_req   (own_req),
        .bnd_req   (bnd_req),
        .head_rd   (head_rd),
        .tail_rd   (tail_rd),
        .next_rd   (next_rd),
        .own_rd    (own_rd),
        .bnd_rd    (bnd_rd)
    );

    // Queue head and tail, indexed by queue (locks low half, conditions high)
    mcv_ram #(.AW(5), .DW(5)) u_head (
        .aclk(aclk), .we(head_req.we), .waddr(head_req.waddr),
        .wdata(head_req.wdata), .raddr(head_req.raddr), .rdata(head_rd)
    );
    mcv_ram #(.AW(5), .DW(5)) u_tail (
        .aclk(aclk), .we(tail_req.we), .waddr(tail_req.waddr),
        .wdata(tail_req.wdata), .raddr(tail_req.raddr), .rdata(tail_rd)
    );
    // Link to the next waiter, indexed by pid
    mcv_ram #(.AW(5), .DW(5)) u_next (
        .aclk(aclk), .we(next_req.we), .waddr(next_req.waddr),
        .wdata(next_req.wdata), .raddr(next_req.raddr), .rdata(next_rd)
    );
    // Lock owner pid
    mcv_ram #(.AW(4), .DW(5)) u_owner (
        .aclk(aclk), .we(own_req.we), .waddr(own_req.waddr),
        .wdata(own_req.wdata), .raddr(own_req.raddr), .rdata(own_rd)
    );
    // Lock bound to each condition
    mcv_ram #(.AW(4), .DW(4)) u_bound (
        .aclk(aclk), .we(bnd_req.we), .waddr(bnd_req.waddr),
        .wdata(bnd_req.wdata), .raddr(bnd_req.raddr), .rdata(bnd_rd)
    );

    // Output register: free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = {4'b0, res};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

`ifndef SYNTHESIS
    // A sleeping caller always comes with success
    a_sleep_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[5] && m_tdata[0]))
        else $error("caller sleeps on a failed request");
    // Failures change nothing, so they report no wake and no handle
    a_fail_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[6] == 1'b0 && m_tdata[4:1] == 4'd0))
        else $error("failed request reports a wake or handle");
    // Wake pid is zero unless a wake is reported
    a_wake_pid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[6]) |-> (m_tdata[11:7] == 5'd0))
        else $error("wake pid set without wake");
    // No new request is taken in the cycle a result is handed over
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("request accepted while a result is pending");
`endif
endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mutex/condvar manager. Requests go in on the
// s_ stream. A predictor keeps its own lock, condition and queue tables and
// works out the result of each accepted request. Every result transfer on
// the m_ stream is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcv_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Idle rates in percent for the request side and the result side
    int unsigned req_idle_pct = 0;
    int unsigned res_idle_pct = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    localparam int unsigned QuietLimit = 5000;

    result_t pending_results[$];

    // Predictor tables. Queues 0..15 belong to locks, 16..31 to conditions.
    bit         lk_used [NumLocks];
    bit         lk_held [NumLocks];
    logic [4:0] lk_owner[NumLocks];
    bit         cv_used [NumConds];
    logic [3:0] cv_lock [NumConds];
    bit         q_busy  [NumLocks + NumConds];
    logic [4:0] q_first [NumLocks + NumConds];
    logic [4:0] q_last  [NumLocks + NumConds];
    logic [4:0] pid_next[NumPids];
    bit         pid_asleep[NumPids];

    mutex_and_condvar_manager_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // --- predictor ---------------------------------------------------------
    function automatic void q_push(int q, logic [4:0] pid);
        if (q_busy[q]) begin
            pid_next[q_last[q]] = pid;
            q_last[q] = pid;
        end else begin
            q_first[q] = pid;
            q_last[q]  = pid;
            q_busy[q]  = 1'b1;
        end
        pid_asleep[pid] = 1'b1;
    endfunction

    function automatic logic [4:0] q_pop(int q);
        logic [4:0] h;
        h = q_first[q];
        if (h == q_last[q]) begin
            q_busy[q] = 1'b0;
        end else begin
            q_first[q] = pid_next[h];
        end
        pid_asleep[h] = 1'b0;
        return h;
    endfunction

    // Pull a pid out of a lock queue wherever it sits
    function automatic bit q_unlink(int q, logic [4:0] pid);
        logic [4:0] cur, prev;
        logic [4:0] dummy;
        prev = '0;
        if (!q_busy[q]) return 1'b0;
        cur = q_first[q];
        for (int n = 0; n < NumPids; n++) begin
            if (cur == pid) begin
                if (n == 0) begin
                    dummy = q_pop(q);
                end else begin
                    if (cur == q_last[q]) q_last[q] = prev;
                    else pid_next[prev] = pid_next[cur];
                    pid_asleep[cur] = 1'b0;
                end
                return 1'b1;
            end
            if (cur == q_last[q]) return 1'b0;
            prev = cur;
            cur  = pid_next[cur];
        end
        return 1'b0;
    endfunction

    function automatic result_t grant_outcome(item_t req);
        result_t    r;
        logic [3:0] h, lk;
        logic [4:0] who;
        int         cq;
        bit         done;
        r    = '0;
        r.status = 1'b1;
        h    = req.handle;
        who  = req.caller_pid;
        done = 1'b0;
        if (pid_asleep[who]) return r;   // a sleeping caller fails everything
        case (req.operation)
            OP_LOCK_CREATE: begin
                for (int i = 0; i < NumLocks && !done; i++) begin
                    if (!lk_used[i]) begin
                        lk_used[i] = 1'b1;
                        lk_held[i] = 1'b0;
                        q_busy[i]  = 1'b0;
                        r.new_handle = 4'(i);
                        r.status = 1'b0;
                        done = 1'b1;
                    end
                end
            end
            OP_ACQUIRE: begin
                if (lk_used[h]) begin
                    r.status = 1'b0;
                    if (!lk_held[h]) begin
                        lk_held[h]  = 1'b1;
                        lk_owner[h] = who;
                    end else if (lk_owner[h] != who) begin
                        q_push(h, who);
                        r.caller_sleeps = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                if (lk_used[h] && lk_held[h] && lk_owner[h] == who) begin
                    r.status = 1'b0;
                    if (q_busy[h]) begin
                        r.wake_pid   = q_pop(h);
                        r.wake_valid = 1'b1;
                        lk_owner[h]  = r.wake_pid;
                    end else begin
                        lk_held[h] = 1'b0;
                    end
                end
            end
            OP_TRANSFER: begin
                if (lk_used[h] && lk_held[h] && lk_owner[h] == who) begin
                    r.status = 1'b0;
                    lk_owner[h] = req.target_pid;
                    if (q_unlink(h, req.target_pid)) begin
                        r.wake_valid = 1'b1;
                        r.wake_pid   = req.target_pid;
                    end
                end
            end
            OP_COND_CREATE: begin
                if (lk_used[h]) begin
                    for (int i = 0; i < NumConds && !done; i++) begin
                        if (!cv_used[i]) begin
                            cv_used[i] = 1'b1;
                            cv_lock[i] = h;
                            q_busy[NumLocks + i] = 1'b0;
                            r.new_handle = 4'(i);
                            r.status = 1'b0;
                            done = 1'b1;
                        end
                    end
                end
            end
            OP_COND_WAIT, OP_COND_SIGNAL: begin
                if (cv_used[h]) begin
                    lk = cv_lock[h];
                    cq = NumLocks + int'(h);
                    if (lk_held[lk] && lk_owner[lk] == who) begin
                        r.status = 1'b0;
                        if (req.operation == OP_COND_WAIT) begin
                            q_push(cq, who);
                            r.caller_sleeps = 1'b1;
                            if (q_busy[lk]) begin
                                r.wake_pid   = q_pop(lk);
                                r.wake_valid = 1'b1;
                                lk_owner[lk] = r.wake_pid;
                            end else begin
                                lk_held[lk] = 1'b0;
                            end
                        end else if (q_busy[cq]) begin
                            // Hoare hand-over: waiter gets the lock, signaller queues
                            r.wake_pid   = q_pop(cq);
                            r.wake_valid = 1'b1;
                            lk_owner[lk] = r.wake_pid;
                            q_push(lk, who);
                            r.caller_sleeps = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // --- request side ------------------------------------------------------
    task automatic send_req(logic [2:0] op, logic [3:0] h, logic [4:0] who,
                            logic [4:0] tgt);
        item_t req;
        req = '{target_pid: tgt, caller_pid: who, handle: h, operation: op};
        s_tdata  <= {7'd0, req};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(grant_outcome(req));
        if ($urandom_range(99) < req_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // --- result side: stalls, checking, watchdog ---------------------------
    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= res_idle_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("timeout: no transfer for %0d cycles", QuietLimit);
                $display("*** FAILED ***");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[11:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), -1);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.new_handle != want.new_handle)
                        report_mismatch("new_handle", got.new_handle, want.new_handle);
                    if (got.caller_sleeps != want.caller_sleeps)
                        report_mismatch("caller_sleeps", got.caller_sleeps,
                                        want.caller_sleeps);
                    if (got.wake_valid != want.wake_valid)
                        report_mismatch("wake_valid", got.wake_valid, want.wake_valid);
                    if (got.wake_pid != want.wake_pid)
                        report_mismatch("wake_pid", got.wake_pid, want.wake_pid);
                end
            end
        end
    end

    // --- tests -------------------------------------------------------------
    // Hand-picked sequence through every operation and corner
    task automatic test_directed();
        send_req(OP_ACQUIRE,     4'd0,  5'd1,  5'd0);  // unused lock
        send_req(OP_LOCK_CREATE, 4'd0,  5'd1,  5'd0);  // lock 0
        send_req(OP_ACQUIRE,     4'd0,  5'd1,  5'd0);
        send_req(OP_ACQUIRE,     4'd0,  5'd1,  5'd0);  // owner again, no-op
        send_req(OP_ACQUIRE,     4'd0,  5'd2,  5'd0);  // sleeps
        send_req(OP_ACQUIRE,     4'd0,  5'd2,  5'd0);  // sleeping caller
        send_req(OP_RELEASE,     4'd0,  5'd3,  5'd0);  // not owner
        send_req(OP_RELEASE,     4'd0,  5'd1,  5'd0);  // hands off to 2
        send_req(OP_TRANSFER,    4'd0,  5'd2,  5'd31); // target not queued
        send_req(OP_ACQUIRE,     4'd0,  5'd6,  5'd0);
        send_req(OP_ACQUIRE,     4'd0,  5'd7,  5'd0);
        send_req(OP_TRANSFER,    4'd0,  5'd31, 5'd7);  // pulls tail out of queue
        send_req(OP_COND_CREATE, 4'd9,  5'd7,  5'd0);  // unused lock
        send_req(OP_COND_CREATE, 4'd0,  5'd7,  5'd0);  // cond 0
        send_req(OP_COND_WAIT,   4'd0,  5'd4,  5'd0);  // not owner
        send_req(OP_COND_WAIT,   4'd0,  5'd7,  5'd0);  // lock goes to 6
        send_req(OP_COND_SIGNAL, 4'd0,  5'd6,  5'd0);  // 7 back, 6 sleeps
        send_req(OP_COND_SIGNAL, 4'd0,  5'd7,  5'd0);  // nobody waiting
        send_req(OP_COND_WAIT,   4'd15, 5'd7,  5'd0);  // unused cond
        send_req(3'd7,           4'd15, 5'd0,  5'd0);  // undefined op
        send_req(OP_RELEASE,     4'd0,  5'd7,  5'd0);  // wakes 6
    endtask

    // Random traffic: callers are often chosen as current owners
    task automatic test_random(int n);
        logic [2:0] op;
        logic [3:0] h;
        logic [4:0] who, tgt;
        for (int i = 0; i < n; i++) begin
            op  = 3'($urandom_range(7));
            if ($urandom_range(99) < 4) op = OP_LOCK_CREATE;
            h   = 4'($urandom_range(15));
            who = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                           : 5'($urandom_range(11));
            tgt = ($urandom_range(1) == 0) ? 5'($urandom_range(31))
                                           : 5'($urandom_range(11));
            if ($urandom_range(99) < 60) begin
                if ((op == OP_COND_WAIT || op == OP_COND_SIGNAL) && cv_used[h]) begin
                    if (lk_held[cv_lock[h]]) who = lk_owner[cv_lock[h]];
                end else if (lk_used[h] && lk_held[h]) begin
                    who = lk_owner[h];
                end
            end
            send_req(op, h, who, tgt);
        end
    endtask

    // Hold the request side until every outstanding result is back
    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        send_req(OP_LOCK_CREATE, 4'd0, 5'd0, 5'd0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        req_idle_pct = 7;  res_idle_pct = 62;
        test_random(450);
        test_drain_pause();
        req_idle_pct = 62; res_idle_pct = 7;
        test_random(450);
        req_idle_pct = 0;  res_idle_pct = 0;
        test_random(450);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
